FILE: rtl/core/sjf_pkg.sv
`timescale 1ns / 1ps
package sjf_pkg;

  localparam int unsigned ReadyDepthDef = 32;

  localparam logic [1:0] RecDone   = 2'd0;
  localparam logic [1:0] RecSum    = 2'd1;
  localparam logic [1:0] RecReject = 2'd2;

  localparam logic [1:0] RsnFull  = 2'd0;
  localparam logic [1:0] RsnOrder = 2'd1;
  localparam logic [1:0] RsnZero  = 2'd2;

  localparam logic KindSubmit = 1'b0;
  localparam logic KindDrain  = 1'b1;

  typedef struct packed {
    logic [15:0] burst;
    logic [31:0] arrival;
    logic [15:0] id;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] job_id;
    logic [31:0] arr_time;
    logic [15:0] run_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] done_job_id;
    logic [39:0] start_at;
    logic [39:0] finish_at;
    logic [39:0] wait_units;
    logic [39:0] turnaround_units;
    logic [1:0]  reject_reason;
    logic [31:0] jobs_done;
    logic [39:0] elapsed_units;
    logic [47:0] wait_sum;
    logic [47:0] turnaround_sum;
    logic        last;
  } out_item_t;

  // true when a is picked ahead of b
  function automatic logic job_better(job_t a, job_t b);
    if (a.burst != b.burst) return a.burst < b.burst;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.id < b.id;
  endfunction

endpackage

FILE: rtl/core/sjf_stream_if.sv
`timescale 1ns / 1ps
interface sjf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/shortest_job_first_scheduler.sv
`timescale 1ns / 1ps
// channel   dir  payload      transfer when
// in_ch     in   in_item_t    in_ch.valid && in_ch.ready
// out_ch    out  out_item_t   out_ch.valid && out_ch.ready
//
// items are taken one at a time; in_ch.ready is high only in the idle state
// one pass: a setup step, a sweep, a pick and a load when a job is dispatched,
// and a decide step; the same sweep also finds the lowest free slot
// a pass that completes a job is followed by another pass; one that completes none ends the item
// a completion is held until the next pass shows whether it ends the item
// reset clears valid bits and totals at once; the job memory needs no clearing
// a result waits in the output register until transferred; the fsm holds meanwhile
module shortest_job_first_scheduler #(
  parameter int unsigned READY_DEPTH = sjf_pkg::ReadyDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sjf_stream_if.sink   in_ch,
  sjf_stream_if.source out_ch
);
  import sjf_pkg::*;

  localparam int unsigned IdxW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(READY_DEPTH + 1);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StScan   = 8'b0000_0010,  // sweep memory for best job and first free slot
    StPick   = 8'b0000_0100,  // read best job back
    StLoad   = 8'b0000_1000,  // start running it
    StDecide = 8'b0001_0000,  // complete, insert or finish
    StEmit   = 8'b0010_0000,  // wait for output transfer
    StRun    = 8'b0100_0000   // settle loop step
  } state_e;

  state_e state_q;

  // job memory, registered read
  job_t             mem_q [READY_DEPTH];
  logic [IdxW-1:0]  rd_addr;
  job_t             rd_q;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  job_t             wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  logic [READY_DEPTH-1:0] vld_q;
  in_item_t  item_q;
  logic      cpu_q;
  job_t      run_q;
  logic [39:0] start_q, busy_q, now_q, lastf_q;
  logic [31:0] cnt_q;
  logic [47:0] wsum_q, tsum_q;

  // scan bookkeeping
  logic [CntW-1:0] scan_q;       // address issued
  logic            rv_q;          // read data valid
  logic [IdxW-1:0] raddr_q;       // address of rd_q
  logic            bfound_q;
  logic [IdxW-1:0] bidx_q;
  job_t            bjob_q;
  logic            ffound_q;
  logic [IdxW-1:0] fidx_q;
  logic            unlim_q;       // drain mode
  logic            insonly_q;     // same arrival as now: insert without dispatch

  out_item_t obuf_q;
  logic      ovld_q;
  logic      held_q;              // completion parked in obuf_q, not yet offered
  logic      after_emit_q;        // 1: go idle after emit, 0: back to decide

  assign in_ch.ready  = (state_q == StIdle);
  assign out_ch.valid = ovld_q;
  assign out_ch.data  = obuf_q;

  function automatic out_item_t reject_rec(logic [15:0] id, logic [1:0] why);
    out_item_t r;
    r = '0;
    r.record_kind   = RecReject;
    r.done_job_id   = id;
    r.reject_reason = why;
    r.last          = 1'b1;
    return r;
  endfunction

  logic [39:0] arr40, w40, t40;
  logic [32:0] cnt_s;
  logic [48:0] ws_s, ts_s;
  logic        limit_ok;
  logic        do_done;
  logic        ins_ok;
  out_item_t   done_rec, sum_rec;

  always_comb begin
    arr40 = {8'd0, run_q.arrival};
    w40   = start_q - arr40;
    t40   = busy_q - arr40;
    cnt_s = {1'b0, cnt_q} + 33'd1;
    ws_s  = {1'b0, wsum_q} + {9'd0, w40};
    ts_s  = {1'b0, tsum_q} + {9'd0, t40};
    limit_ok = unlim_q || (busy_q < {8'd0, item_q.arr_time});
    do_done  = cpu_q && limit_ok && !insonly_q;
    ins_ok   = !do_done && !unlim_q && ffound_q;
    done_rec = '0;
    done_rec.record_kind      = RecDone;
    done_rec.done_job_id      = run_q.id;
    done_rec.start_at         = start_q;
    done_rec.finish_at        = busy_q;
    done_rec.wait_units       = w40;
    done_rec.turnaround_units = t40;
    sum_rec = '0;
    sum_rec.record_kind    = RecSum;
    sum_rec.jobs_done      = cnt_q;
    sum_rec.elapsed_units  = lastf_q;
    sum_rec.wait_sum       = wsum_q;
    sum_rec.turnaround_sum = tsum_q;
    sum_rec.last           = 1'b1;
  end

  assign rd_addr = (state_q == StPick) ? bidx_q : scan_q[IdxW-1:0];
  assign wr_addr = fidx_q;
  assign wr_data = '{burst: item_q.run_len, arrival: item_q.arr_time,
                     id: item_q.job_id};
  assign wr_en   = (state_q == StDecide) && ins_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= '0; cpu_q <= 1'b0; run_q <= '0;
      start_q <= '0; busy_q <= '0; now_q <= '0; lastf_q <= '0;
      cnt_q <= '0; wsum_q <= '0; tsum_q <= '0;
      scan_q <= '0; rv_q <= 1'b0; raddr_q <= '0;
      bfound_q <= 1'b0; bidx_q <= '0; bjob_q <= '0;
      ffound_q <= 1'b0; fidx_q <= '0; unlim_q <= 1'b0; insonly_q <= 1'b0;
      ovld_q <= 1'b0; held_q <= 1'b0; after_emit_q <= 1'b0;
      item_q <= '0; obuf_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_ch.valid) begin
            item_q <= in_ch.data;
            unlim_q <= (in_ch.data.kind == KindDrain);
            // same time: insert only, no dispatch and no settling
            insonly_q <= (in_ch.data.kind == KindSubmit) &&
                         ({8'd0, in_ch.data.arr_time} == now_q);
            if (in_ch.data.kind == KindSubmit &&
                {8'd0, in_ch.data.arr_time} < now_q) begin
              obuf_q <= reject_rec(in_ch.data.job_id, RsnOrder);
              ovld_q <= 1'b1; after_emit_q <= 1'b1; state_q <= StEmit;
            end else if (in_ch.data.kind == KindSubmit && in_ch.data.run_len == '0) begin
              obuf_q <= reject_rec(in_ch.data.job_id, RsnZero);
              ovld_q <= 1'b1; after_emit_q <= 1'b1; state_q <= StEmit;
            end else begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          // start a sweep: finds best job and lowest free slot
          scan_q <= '0; rv_q <= 1'b0; bfound_q <= 1'b0; ffound_q <= 1'b0;
          state_q <= StScan;
        end
        StScan: begin
          rv_q <= (scan_q < CntW'(READY_DEPTH));
          raddr_q <= scan_q[IdxW-1:0];
          if (scan_q < CntW'(READY_DEPTH)) scan_q <= scan_q + CntW'(1);
          if (rv_q) begin
            if (vld_q[raddr_q]) begin
              if (!bfound_q || job_better(rd_q, bjob_q)) begin
                bfound_q <= 1'b1; bidx_q <= raddr_q; bjob_q <= rd_q;
              end
            end else if (!ffound_q) begin
              ffound_q <= 1'b1; fidx_q <= raddr_q;
            end
          end
          if (!rv_q && scan_q == CntW'(READY_DEPTH)) begin
            // no job found, insert-only pass or cpu busy: skip dispatch
            if (bfound_q && !cpu_q && !insonly_q) begin
              state_q <= StPick;
            end else begin
              state_q <= StDecide;
            end
          end
        end
        StPick: state_q <= StLoad;
        StLoad: begin
          vld_q[bidx_q] <= 1'b0;
          if (!ffound_q || bidx_q < fidx_q) begin
            ffound_q <= 1'b1; fidx_q <= bidx_q;
          end
          run_q <= bjob_q;
          start_q <= now_q;
          busy_q <= now_q + {24'd0, bjob_q.burst};
          cpu_q <= 1'b1;
          state_q <= StDecide;
        end
        StDecide: begin
          if (held_q && !ins_ok) begin
            // another record follows, so the parked completion is not the last
            ovld_q <= 1'b1; held_q <= 1'b0; after_emit_q <= 1'b0; state_q <= StEmit;
          end else if (do_done) begin
            obuf_q <= done_rec;
            now_q <= busy_q; lastf_q <= busy_q;
            cnt_q <= cnt_s[32] ? '1 : cnt_s[31:0];
            wsum_q <= ws_s[48] ? '1 : ws_s[47:0];
            tsum_q <= ts_s[48] ? '1 : ts_s[47:0];
            cpu_q <= 1'b0;
            held_q <= 1'b1; state_q <= StRun;
          end else if (unlim_q) begin
            obuf_q <= sum_rec;
            ovld_q <= 1'b1; after_emit_q <= 1'b1; state_q <= StEmit;
          end else if (ffound_q) begin
            now_q <= {8'd0, item_q.arr_time};
            vld_q[fidx_q] <= 1'b1;
            if (held_q) begin
              // silent insert: the parked completion ends the item
              obuf_q.last <= 1'b1;
              ovld_q <= 1'b1; held_q <= 1'b0; after_emit_q <= 1'b1; state_q <= StEmit;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            now_q <= {8'd0, item_q.arr_time};
            obuf_q <= reject_rec(item_q.job_id, RsnFull);
            ovld_q <= 1'b1; after_emit_q <= 1'b1; state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_ch.ready) begin
            ovld_q <= 1'b0;
            state_q <= after_emit_q ? StIdle : StDecide;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !out_ch.ready && state_q == StEmit |=> $stable(obuf_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |-> !ovld_q)
    else $error("item taken with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> vld_q[bidx_q])
    else $error("dispatched an empty slot");
endmodule

FILE: bench/sjf_checker.sv
`timescale 1ns / 1ps
module sjf_checker
  import sjf_pkg::*;
#(
  parameter int unsigned READY_DEPTH = ReadyDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sjf_stream_if  in_ch,
  sjf_stream_if  out_ch,
  output int     errors_o,
  output int     pending_o,
  output int     done_seen_o,
  output int     reject_seen_o,
  output int     summary_seen_o
);

  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

  // scheduler shadow state
  job_t        slot_job [READY_DEPTH];
  logic        slot_used [READY_DEPTH];
  logic        cpu_busy;
  job_t        cur_job;
  logic [39:0] cur_start;
  logic [39:0] busy_until;
  logic [39:0] now_t;
  logic [31:0] done_total;
  logic [39:0] last_fin;
  logic [47:0] wait_acc;
  logic [47:0] turn_acc;

  out_item_t   sched_records [$];

  function automatic logic picked_first(job_t a, job_t b);
    if (a.burst != b.burst) return a.burst < b.burst;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.id < b.id;
  endfunction

  function automatic logic [47:0] sat48(logic [47:0] a, logic [39:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction

  task automatic pick_next();
    int best;
    best = -1;
    for (int i = 0; i < READY_DEPTH; i++)
      if (slot_used[i] && (best < 0 || picked_first(slot_job[i], slot_job[best]))) best = i;
    if (best >= 0) begin
      slot_used[best] = 1'b0;
      cur_job    = slot_job[best];
      cur_start  = now_t;
      busy_until = (now_t + {24'd0, cur_job.burst}) & Max40;
      cpu_busy   = 1'b1;
    end
  endtask

  task automatic finish_job();
    out_item_t   r;
    logic [39:0] w;
    logic [39:0] t;
    w = cur_start - {8'd0, cur_job.arrival};
    t = busy_until - {8'd0, cur_job.arrival};
    r = '0;
    r.record_kind      = RecDone;
    r.done_job_id      = cur_job.id;
    r.start_at         = cur_start;
    r.finish_at        = busy_until;
    r.wait_units       = w;
    r.turnaround_units = t;
    sched_records = {sched_records, r};
    now_t    = busy_until;
    last_fin = busy_until;
    if (done_total != 32'hFFFF_FFFF) done_total++;
    wait_acc = sat48(wait_acc, w);
    turn_acc = sat48(turn_acc, t);
    cpu_busy = 1'b0;
  endtask

  task automatic run_until(logic all, logic [39:0] limit);
    forever begin
      if (!cpu_busy) pick_next();
      if (cpu_busy && (all || busy_until < limit)) finish_job();
      else break;
    end
  endtask

  task automatic add_reject(logic [15:0] id, logic [1:0] why);
    out_item_t r;
    r = '0;
    r.record_kind   = RecReject;
    r.done_job_id   = id;
    r.reject_reason = why;
    sched_records = {sched_records, r};
  endtask

  task automatic predict_item(in_item_t it);
    int        first;
    int        free_slot;
    out_item_t r;
    first = sched_records.size();
    if (it.kind == KindDrain) begin
      run_until(1'b1, '0);
      r = '0;
      r.record_kind    = RecSum;
      r.jobs_done      = done_total;
      r.elapsed_units  = last_fin;
      r.wait_sum       = wait_acc;
      r.turnaround_sum = turn_acc;
      sched_records = {sched_records, r};
    end else if ({8'd0, it.arr_time} < now_t) begin
      add_reject(it.job_id, RsnOrder);
    end else if (it.run_len == '0) begin
      add_reject(it.job_id, RsnZero);
    end else begin
      if ({8'd0, it.arr_time} > now_t) begin
        run_until(1'b0, {8'd0, it.arr_time});
        now_t = {8'd0, it.arr_time};
      end
      free_slot = -1;
      for (int i = 0; i < READY_DEPTH; i++)
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) add_reject(it.job_id, RsnFull);
      else begin
        slot_job[free_slot]  = '{burst: it.run_len, arrival: it.arr_time,
                                 id: it.job_id};
        slot_used[free_slot] = 1'b1;
      end
    end
    if (sched_records.size() > first) sched_records[$].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < READY_DEPTH; i++) slot_used[i] = 1'b0;
      cpu_busy = 0; cur_job = '0; cur_start = '0; busy_until = '0; now_t = '0;
      done_total = '0; last_fin = '0; wait_acc = '0; turn_acc = '0;
      sched_records.delete();
      errors_o = 0; done_seen_o = 0; reject_seen_o = 0; summary_seen_o = 0;
      pending_o = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        out_item_t got, want;
        got = out_ch.data;
        case (got.record_kind)
          RecDone:   done_seen_o++;
          RecReject: reject_seen_o++;
          default:   summary_seen_o++;
        endcase
        if (sched_records.size() == 0) begin
          $display("%0t: unexpected record, expected none actual %h", $time, got);
          errors_o++;
        end else begin
          want = sched_records.pop_front();
          check_field("record_kind", 48'(want.record_kind), 48'(got.record_kind));
          check_field("done_job_id", 48'(want.done_job_id), 48'(got.done_job_id));
          check_field("start_at", 48'(want.start_at), 48'(got.start_at));
          check_field("finish_at", 48'(want.finish_at), 48'(got.finish_at));
          check_field("wait_units", 48'(want.wait_units), 48'(got.wait_units));
          check_field("turnaround_units", 48'(want.turnaround_units),
                      48'(got.turnaround_units));
          check_field("reject_reason", 48'(want.reject_reason), 48'(got.reject_reason));
          check_field("jobs_done", 48'(want.jobs_done), 48'(got.jobs_done));
          check_field("elapsed_units", 48'(want.elapsed_units), 48'(got.elapsed_units));
          check_field("wait_sum", want.wait_sum, got.wait_sum);
          check_field("turnaround_sum", want.turnaround_sum, got.turnaround_sum);
          check_field("last", 48'(want.last), 48'(got.last));
        end
      end
      pending_o = sched_records.size();
    end
  end

endmodule

FILE: bench/shortest_job_first_scheduler_test.sv
`timescale 1ns / 1ps
module shortest_job_first_scheduler_test;
  import sjf_pkg::*;

  logic clk_i;
  logic rst_ni;

  sjf_stream_if #(.payload_t(in_item_t))  in_ch ();
  sjf_stream_if #(.payload_t(out_item_t)) out_ch ();

  int errors, pending, done_seen, reject_seen, summary_seen;
  int items_sent;

  // idle pattern selector: 0 means both sides run without gaps
  int idle_mode;
  // tb view of the latest arrival submitted
  logic [31:0] arr_now;

  shortest_job_first_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sjf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .errors_o       (errors),
    .pending_o      (pending),
    .done_seen_o    (done_seen),
    .reject_seen_o  (reject_seen),
    .summary_seen_o (summary_seen)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    if (idle_mode == 0) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, changed at the falling edge
  int stall_left;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left   <= gap_len();
    end
  end

  // one transfer on the job channel; called at a falling edge, returns at one
  task automatic send_item(input logic kind, input logic [15:0] id,
                           input logic [31:0] arr, input logic [15:0] burst);
    int gap;
    in_item_t it;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it = '{kind: kind, job_id: id, arr_time: arr, run_len: burst};
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic submit(input logic [15:0] id, input logic [31:0] arr,
                        input logic [15:0] burst);
    send_item(KindSubmit, id, arr, burst);
    if (arr > arr_now && burst != 0) arr_now = arr;
  endtask

  // random traffic: mostly ordered submissions, some drains and bad jobs
  task automatic random_item();
    int p;
    logic [15:0] burst;
    p = $urandom_range(0, 99);
    burst = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 15));
    if (p < 4) send_item(KindDrain, 16'($urandom), 32'($urandom), 16'($urandom));
    else if (p < 7) submit(16'($urandom), arr_now, 16'd0);
    else if (p < 10 && arr_now > 0)
      submit(16'($urandom), 32'($urandom_range(0, arr_now - 1)), burst);
    else if (p < 25) submit(16'($urandom), arr_now, burst);
    else submit(16'($urandom), arr_now + 32'($urandom_range(1, 12)), burst);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    idle_mode   = 1;
    items_sent  = 0;
    arr_now     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ties on burst, then arrival, then id; a full tie on identical jobs; a zero burst and a late arrival
    submit(16'hFFFF, 32'd0, 16'd1);
    submit(16'h0000, 32'd0, 16'd1);
    submit(16'h0007, 32'd0, 16'd1);
    submit(16'h0007, 32'd0, 16'd1);
    submit(16'h0010, 32'd0, 16'hFFFF);
    submit(16'h0011, 32'd0, 16'd0);
    submit(16'h0012, 32'd5, 16'd3);
    submit(16'h0013, 32'd2, 16'd4);
    send_item(KindDrain, '0, '0, '0);
    // drain with nothing queued
    send_item(KindDrain, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);

    // overfill the ready set at one instant well past the drained time,
    // then step forward by one
    for (int i = 0; i < 34; i++)
      submit(16'(16'h0100 + i), arr_now + ((i == 0) ? 32'h0010_0000 : 32'd0),
             16'($urandom_range(1, 40)));
    submit(16'h0200, arr_now + 1, 16'd2);
    send_item(KindDrain, '0, '0, '0);

    // random part, alternating between idling and full-rate stretches
    for (int i = 0; i < 210; i++) begin
      if (i % 40 == 0) idle_mode = (i / 40) % 3;
      random_item();
    end
    idle_mode = 1;

    // top of the arrival range, last completions spill past 32 bits
    submit(16'hA5A5, 32'hFFFF_0000, 16'hFFFF);
    submit(16'h5A5A, 32'hFFFF_FFFF, 16'hFFFF);
    submit(16'h5A5B, 32'hFFFF_FFFF, 16'h8000);
    submit(16'h5A5C, 32'h7FFF_FFFF, 16'd1);
    send_item(KindDrain, '0, '0, '0);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (2000) @(negedge clk_i);

    $display("run: %0d inputs, %0d completions, %0d rejects, %0d summaries",
             items_sent, done_seen, reject_seen, summary_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
